// ===== rtl/dfcc_pkg.sv =====
`default_nettype none

package dfcc_pkg;

	// curve storage
	localparam int unsigned STORED_POINTS = 12;
	localparam logic [3:0]  CURVE_POINTS  = 4'd12;
	localparam int unsigned WORD_W        = 60;
	localparam int unsigned POINT_W       = 15;
	localparam int unsigned TEMP_W        = 7;
	localparam int unsigned DUTY_W        = 8;
	localparam int unsigned AVG_W         = 15;

	localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd198;
	localparam logic [DUTY_W-1:0] HOLD_BAND = 8'd6;

	// average weights, sum to 256
	localparam logic [7:0] ALPHA_KEEP = 8'd205;
	localparam logic [7:0] ALPHA_NEW  = 8'd51;
	localparam logic [15:0] ROUND_HALF = 16'd128;

	// serial divider sizes
	localparam int unsigned NUM_W     = 15;
	localparam int unsigned DEN_W     = 7;
	localparam int unsigned DIV_STEPS = NUM_W;
	localparam int unsigned DIV_CNT_W = 4;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_CPU_A  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CPU_B  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CPU_C  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYS_A  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SYS_B  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SYS_C  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTS = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_CRIT   = 4'd7;

	localparam logic [WORD_W-1:0] RST_CPU_A  = 60'd633258712040868864;
	localparam logic [WORD_W-1:0] RST_CPU_B  = 60'd25430;
	localparam logic [WORD_W-1:0] RST_CPU_C  = 60'd0;
	localparam logic [WORD_W-1:0] RST_SYS_A  = 60'd767597435841682304;
	localparam logic [WORD_W-1:0] RST_SYS_B  = 60'd25404;
	localparam logic [WORD_W-1:0] RST_SYS_C  = 60'd0;
	localparam logic [7:0]        RST_COUNTS = 8'd85;
	localparam logic [13:0]       RST_CRIT   = 14'd7768;

	typedef enum logic [3:0] {
		S_IDLE,
		S_AVG,
		S_ROUND,
		S_FIRST,
		S_LAST,
		S_SCAN,
		S_MUL,
		S_DIV,
		S_FINISH,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/dfcc_div.sv =====
`default_nettype none

module dfcc_div
	import dfcc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]     rem_q;
	logic [NUM_W-1:0]     quo_q;
	logic [DEN_W-1:0]     den_q;

	logic [DEN_W:0]       trial;
	logic                 ge;
	logic [DEN_W:0]       rem_next;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial    = {rem_q, quo_q[NUM_W-1]};
		ge       = trial >= {1'b0, den_q};
		rem_next = ge ? trial - {1'b0, den_q} : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= rem_next[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign rsp = {done_q, quo_q};

endmodule

`default_nettype wire

// ===== rtl/dual_fan_curve_controller.sv =====
`default_nettype none

// Two-channel fan duty controller. Each input item carries a raw CPU and a raw
// system temperature with their present flags; each result carries both duties
// (198 is full) and both smoothed temperatures with their valid flags. The
// channels run one after the other through one small sequencer: average
// update, rounding, a curve scan that reads one point per cycle, and a 15-step
// serial divider for the interpolation, shared by both channels. A channel
// stops at the first point (or has no average or an empty curve), clamps at
// the last point, or scans on and interpolates; the point scan and the wait
// on the divider make the interpolating path the longest. A finished item also
// waits until the output register is free. A new item is taken once the
// previous one is in the output register, even while that result still waits.
// Configuration writes are always ready, and a write to an index up to 7 clears
// the held duties of both channels; write only while no item is in flight.
module dual_fan_curve_controller
	import dfcc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// [6:0] cpu_temp_raw, [7] cpu_temp_ok, [14:8] sys_temp_raw, [15] sys_temp_ok
	input  wire logic [15:0]          s_axis_tdata,

	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// [7:0] cpu_pwm, [15:8] sys_pwm, [22:16] cpu_temp_smooth, [23] cpu_smooth_ok,
	// [30:24] sys_temp_smooth, [31] sys_smooth_ok
	output logic [31:0]               m_axis_tdata,

	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data
);

	state_t state_q, state_d;

	// configuration
	logic [WORD_W-1:0] curve_q [2][3];
	logic [7:0]        counts_q;
	logic [13:0]       crit_q;
	logic              cfg_wr;
	logic              held_clr;

	// per-channel state
	logic [AVG_W-1:0]  avg_q      [2];
	logic              avg_ok_q   [2];
	logic [DUTY_W-1:0] held_q     [2];
	logic              held_ok_q  [2];
	logic [TEMP_W-1:0] smooth_q   [2];

	// item registers
	logic              ch_q;
	logic [TEMP_W-1:0] raw_q [2];
	logic              ok_q  [2];
	logic [TEMP_W-1:0] temp_q;
	logic [3:0]        pidx_q;
	logic [TEMP_W-1:0] prev_t_q, cur_t_q;
	logic [DUTY_W-1:0] prev_d_q, cur_d_q, duty_q;
	logic              neg_q;

	logic              out_valid_q;
	logic [31:0]       out_data_q;

	// point fetch
	logic [WORD_W-1:0]  word_sel;
	logic [POINT_W-1:0] point;
	logic [TEMP_W-1:0]  pt_t;
	logic [DUTY_W-1:0]  pt_d;
	logic [3:0]         n_raw, n_pts, n_last;

	// arithmetic
	logic [23:0]        avg_sum;
	logic [AVG_W-1:0]   avg_new;
	logic [15:0]        round_sum;
	logic [DUTY_W-1:0]  dd;
	logic [TEMP_W-1:0]  dt;
	logic [DUTY_W-1:0]  q8;
	logic [DUTY_W-1:0]  d_fin, diff;
	logic               take;
	logic               out_free;

	div_req_t div_req;
	div_rsp_t div_rsp;

	dfcc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign held_clr  = cfg_wr && (cfg_index <= CFG_CRIT);
	assign out_free  = !out_valid_q || m_axis_tready;

	always_comb begin
		case (pidx_q[3:2])
			2'd0:    word_sel = curve_q[ch_q][0];
			2'd1:    word_sel = curve_q[ch_q][1];
			default: word_sel = curve_q[ch_q][2];
		endcase
		case (pidx_q[1:0])
			2'd0:    point = word_sel[14:0];
			2'd1:    point = word_sel[29:15];
			2'd2:    point = word_sel[44:30];
			default: point = word_sel[59:45];
		endcase
		pt_t   = point[6:0];
		pt_d   = (point[14:7] > DUTY_FULL) ? DUTY_FULL : point[14:7];
		n_raw  = ch_q ? counts_q[7:4] : counts_q[3:0];
		n_pts  = (n_raw > CURVE_POINTS) ? CURVE_POINTS : n_raw;
		n_last = n_pts - 4'd1;
	end

	always_comb begin
		avg_sum   = 24'(avg_q[ch_q]) * 24'(ALPHA_KEEP)
		          + 24'({raw_q[ch_q], 8'b0}) * 24'(ALPHA_NEW);
		avg_new   = avg_sum[22:8];
		round_sum = 16'(avg_q[ch_q]) + ROUND_HALF;
		dd        = (cur_d_q >= prev_d_q) ? cur_d_q - prev_d_q : prev_d_q - cur_d_q;
		dt        = temp_q - prev_t_q;
		q8        = div_rsp.quot[DUTY_W-1:0];
		d_fin     = (ok_q[ch_q] && raw_q[ch_q] >= (ch_q ? crit_q[13:7] : crit_q[6:0]))
		          ? DUTY_FULL : duty_q;
		diff      = (d_fin >= held_q[ch_q]) ? d_fin - held_q[ch_q] : held_q[ch_q] - d_fin;
		take      = !held_ok_q[ch_q] || d_fin == DUTY_FULL || diff >= HOLD_BAND;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (s_axis_tvalid) state_d = S_AVG;
			S_AVG:    state_d = S_ROUND;
			S_ROUND:  state_d = S_FIRST;
			S_FIRST: begin
				if (!avg_ok_q[ch_q] || n_pts == 4'd0 || temp_q <= pt_t) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_LAST;
				end
			end
			S_LAST:   state_d = (temp_q >= pt_t) ? S_FINISH : S_SCAN;
			S_SCAN:   if (temp_q <= pt_t) state_d = S_MUL;
			S_MUL:    state_d = S_DIV;
			S_DIV:    if (div_rsp.done) state_d = S_FINISH;
			S_FINISH: state_d = ch_q ? S_EMIT : S_AVG;
			S_EMIT:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		div_req.start = (state_q == S_MUL);
		div_req.num   = NUM_W'(dd) * NUM_W'(dt);
		div_req.den   = cur_t_q - prev_t_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			ch_q        <= 1'b0;
			curve_q[0][0] <= RST_CPU_A;
			curve_q[0][1] <= RST_CPU_B;
			curve_q[0][2] <= RST_CPU_C;
			curve_q[1][0] <= RST_SYS_A;
			curve_q[1][1] <= RST_SYS_B;
			curve_q[1][2] <= RST_SYS_C;
			counts_q    <= RST_COUNTS;
			crit_q      <= RST_CRIT;
			for (int c = 0; c < 2; c++) begin
				avg_q[c]     <= '0;
				avg_ok_q[c]  <= 1'b0;
				held_q[c]    <= '0;
				held_ok_q[c] <= 1'b0;
				smooth_q[c]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr) begin
				unique case (cfg_index)
					CFG_CPU_A:  curve_q[0][0] <= cfg_data;
					CFG_CPU_B:  curve_q[0][1] <= cfg_data;
					CFG_CPU_C:  curve_q[0][2] <= cfg_data;
					CFG_SYS_A:  curve_q[1][0] <= cfg_data;
					CFG_SYS_B:  curve_q[1][1] <= cfg_data;
					CFG_SYS_C:  curve_q[1][2] <= cfg_data;
					CFG_COUNTS: counts_q <= cfg_data[7:0];
					CFG_CRIT:   crit_q <= cfg_data[13:0];
					default:    ;
				endcase
			end
			if (held_clr) begin
				held_ok_q[0] <= 1'b0;
				held_ok_q[1] <= 1'b0;
			end

			case (state_q)
				S_IDLE: ch_q <= 1'b0;
				S_AVG: begin
					if (ok_q[ch_q]) begin
						avg_ok_q[ch_q] <= 1'b1;
						avg_q[ch_q]    <= avg_ok_q[ch_q] ? avg_new : {raw_q[ch_q], 8'b0};
					end
				end
				S_ROUND: smooth_q[ch_q] <= avg_ok_q[ch_q] ? round_sum[14:8] : '0;
				S_FINISH: begin
					if (take) begin
						held_q[ch_q] <= d_fin;
						if (!held_clr) held_ok_q[ch_q] <= 1'b1;
					end
					ch_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				raw_q[0] <= s_axis_tdata[6:0];
				ok_q[0]  <= s_axis_tdata[7];
				raw_q[1] <= s_axis_tdata[14:8];
				ok_q[1]  <= s_axis_tdata[15];
			end
			S_ROUND: begin
				temp_q <= round_sum[14:8];
				pidx_q <= '0;
			end
			S_FIRST: begin
				duty_q   <= (!avg_ok_q[ch_q] || n_pts == 4'd0) ? DUTY_FULL : pt_d;
				prev_t_q <= pt_t;
				prev_d_q <= pt_d;
				pidx_q   <= n_last;
			end
			S_LAST: begin
				duty_q <= pt_d;
				pidx_q <= 4'd1;
			end
			S_SCAN: begin
				if (temp_q <= pt_t) begin
					cur_t_q <= pt_t;
					cur_d_q <= pt_d;
				end else begin
					prev_t_q <= pt_t;
					prev_d_q <= pt_d;
					pidx_q   <= pidx_q + 4'd1;
				end
			end
			S_MUL: neg_q <= cur_d_q < prev_d_q;
			S_DIV: if (div_rsp.done) duty_q <= neg_q ? prev_d_q - q8 : prev_d_q + q8;
			S_EMIT: begin
				if (out_free) begin
					out_data_q <= {avg_ok_q[1], smooth_q[1], avg_ok_q[0], smooth_q[0],
					               held_q[1], held_q[0]};
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== tb/tb_dual_fan_curve_controller.sv =====
`timescale 1ns / 1ps

module tb_dual_fan_curve_controller;
	import dfcc_pkg::*;

	typedef struct packed {
		logic              sys_ok;
		logic [TEMP_W-1:0] sys_raw;
		logic              cpu_ok;
		logic [TEMP_W-1:0] cpu_raw;
	} temp_item_t;

	typedef struct packed {
		logic              sys_ok;
		logic [TEMP_W-1:0] sys_smooth;
		logic              cpu_ok;
		logic [TEMP_W-1:0] cpu_smooth;
		logic [DUTY_W-1:0] sys_pwm;
		logic [DUTY_W-1:0] cpu_pwm;
	} fan_result_t;

	typedef enum {CURVE_SORTED, CURVE_SCRAMBLED, CURVE_STEPPED} curve_kind_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 24;
	localparam int PHASES      = 10;
	localparam int HALF_BATCH  = 19;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_IDX = '1;

	class duty_scoreboard;
		logic [WORD_W-1:0] curve_word [2][3];
		logic [7:0]        point_counts;
		logic [13:0]       crit_limits;
		logic [AVG_W-1:0]  avg_q78 [2];
		logic              avg_ok [2];
		logic [DUTY_W-1:0] held_duty [2];
		logic              held_ok [2];
		fan_result_t       expected_results [$];
		int items, results, writes, mismatches;

		function new();
			curve_word[0][0] = RST_CPU_A;
			curve_word[0][1] = RST_CPU_B;
			curve_word[0][2] = RST_CPU_C;
			curve_word[1][0] = RST_SYS_A;
			curve_word[1][1] = RST_SYS_B;
			curve_word[1][2] = RST_SYS_C;
			point_counts = RST_COUNTS;
			crit_limits  = RST_CRIT;
			for (int ch = 0; ch < 2; ch++) begin
				avg_q78[ch]   = '0;
				avg_ok[ch]    = 1'b0;
				held_duty[ch] = '0;
				held_ok[ch]   = 1'b0;
			end
		endfunction

		function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
			writes++;
			case (idx)
				CFG_CPU_A, CFG_CPU_B, CFG_CPU_C,
				CFG_SYS_A, CFG_SYS_B, CFG_SYS_C: curve_word[idx / 3][idx % 3] = val;
				CFG_COUNTS: point_counts = val[7:0];
				CFG_CRIT: crit_limits = val[13:0];
				default: return;
			endcase
			held_ok[0] = 1'b0;
			held_ok[1] = 1'b0;
		endfunction

		function int point_temp(int ch, int k);
			logic [WORD_W-1:0] w;
			w = curve_word[ch][k / 4];
			return int'(w[POINT_W * (k % 4) +: TEMP_W]);
		endfunction

		function int point_duty(int ch, int k);
			logic [WORD_W-1:0] w;
			int d;
			w = curve_word[ch][k / 4];
			d = int'(w[POINT_W * (k % 4) + TEMP_W +: DUTY_W]);
			return (d > int'(DUTY_FULL)) ? int'(DUTY_FULL) : d;
		endfunction

		// piecewise-linear lookup, scanned as stored (no sorting)
		function int lookup_curve(int ch, int t);
			int n, lim, t0, t1, d0, d1;
			n = ch ? int'(point_counts[7:4]) : int'(point_counts[3:0]);
			lim = (int'(CURVE_POINTS) < int'(STORED_POINTS)) ? int'(CURVE_POINTS)
				: int'(STORED_POINTS);
			if (n > lim)
				n = lim;
			if (n == 0)
				return int'(DUTY_FULL);
			if (t <= point_temp(ch, 0))
				return point_duty(ch, 0);
			if (t >= point_temp(ch, n - 1))
				return point_duty(ch, n - 1);
			for (int i = 1; i < n; i++) begin
				t1 = point_temp(ch, i);
				if (t <= t1) begin
					t0 = point_temp(ch, i - 1);
					d0 = point_duty(ch, i - 1);
					d1 = point_duty(ch, i);
					if (t1 == t0)
						return d1;
					return d0 + (d1 - d0) * (t - t0) / (t1 - t0);
				end
			end
			return point_duty(ch, n - 1);
		endfunction

		function logic [DUTY_W-1:0] channel_duty(int ch, logic [TEMP_W-1:0] raw, logic ok,
				output logic [TEMP_W-1:0] smooth);
			int duty, crit, diff;
			int unsigned blend;
			crit = ch ? int'(crit_limits[13:7]) : int'(crit_limits[6:0]);
			if (ok) begin
				if (!avg_ok[ch]) begin
					avg_q78[ch] = {raw, 8'd0};
					avg_ok[ch]  = 1'b1;
				end else begin
					blend = (32'(avg_q78[ch]) * 205 + 32'(raw) * 256 * 51) >> 8;
					avg_q78[ch] = blend[AVG_W-1:0];
				end
			end
			if (avg_ok[ch]) begin
				blend  = (32'(avg_q78[ch]) + 128) >> 8;
				smooth = blend[TEMP_W-1:0];
				duty   = lookup_curve(ch, int'(smooth));
			end else begin
				smooth = '0;
				duty   = int'(DUTY_FULL);
			end
			if (ok && int'(raw) >= crit)
				duty = int'(DUTY_FULL);
			diff = duty - int'(held_duty[ch]);
			if (diff < 0)
				diff = -diff;
			// deadband: a move to full duty always passes
			if (!held_ok[ch] || duty == int'(DUTY_FULL) || diff >= int'(HOLD_BAND)) begin
				held_duty[ch] = duty[DUTY_W-1:0];
				held_ok[ch]   = 1'b1;
			end
			return held_duty[ch];
		endfunction

		function void take_sample(temp_item_t it);
			fan_result_t e;
			e.cpu_pwm = channel_duty(0, it.cpu_raw, it.cpu_ok, e.cpu_smooth);
			e.sys_pwm = channel_duty(1, it.sys_raw, it.sys_ok, e.sys_smooth);
			e.cpu_ok = avg_ok[0];
			e.sys_ok = avg_ok[1];
			expected_results.push_back(e);
			items++;
		endfunction

		function void check_result(fan_result_t got);
			fan_result_t e;
			results++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing expected: %h", results, got);
				return;
			end
			e = expected_results.pop_front();
			if (got.cpu_pwm !== e.cpu_pwm || got.sys_pwm !== e.sys_pwm ||
					got.cpu_smooth !== e.cpu_smooth || got.cpu_ok !== e.cpu_ok ||
					got.sys_smooth !== e.sys_smooth || got.sys_ok !== e.sys_ok) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d mismatch (exp/got): cpu duty %0d/%0d smooth %0d/%0d ok %0b/%0b",
						results, e.cpu_pwm, got.cpu_pwm, e.cpu_smooth, got.cpu_smooth,
						e.cpu_ok, got.cpu_ok);
					$display("    sys duty %0d/%0d smooth %0d/%0d ok %0b/%0b",
						e.sys_pwm, got.sys_pwm, e.sys_smooth, got.sys_smooth,
						e.sys_ok, got.sys_ok);
				end
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	temp_item_t           s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [31:0]          m_axis_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data = '0;

	logic steady = 1'b0;
	int   cycles = 0;
	int   cpu_walk = 45;
	int   sys_walk = 35;

	duty_scoreboard sb = new();

	dual_fan_curve_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic temp_item_t mk_item(int cpu_raw, bit cpu_ok, int sys_raw, bit sys_ok);
		temp_item_t it;
		it.cpu_raw = cpu_raw[TEMP_W-1:0];
		it.cpu_ok  = cpu_ok;
		it.sys_raw = sys_raw[TEMP_W-1:0];
		it.sys_ok  = sys_ok;
		return it;
	endfunction

	function automatic int next_temp(int cur);
		int t;
		t = cur + int'($urandom_range(12)) - 6;
		if ($urandom_range(99) < 5)
			t = $urandom_range(127);
		if (t < 0)
			t = 0;
		if (t > 127)
			t = 127;
		return t;
	endfunction

	// called at a clock edge; leaves tvalid high on return
	task automatic send_item(temp_item_t it);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= it;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.take_sample(it);
	endtask

	// leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.apply_write(idx, val);
	endtask

	task automatic wait_results();
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_curve(int ch, curve_kind_t kind);
		logic [WORD_W-1:0] w [3];
		int t, d;
		t = $urandom_range(50);
		d = $urandom_range(100);
		for (int j = 0; j < 3; j++)
			w[j] = '0;
		for (int k = 0; k < STORED_POINTS; k++) begin
			case (kind)
				CURVE_SORTED: begin
					t += $urandom_range(1, 12);
					d = ($urandom_range(99) < 30) ? $urandom_range(255) : d + $urandom_range(25);
				end
				CURVE_STEPPED: begin
					// repeated temperatures give zero-width segments
					t += $urandom_range(2);
					d = ($urandom_range(99) < 50) ? $urandom_range(255) : d;
				end
				default: begin
					t = $urandom_range(127);
					d = $urandom_range(255);
				end
			endcase
			if (t > 127)
				t = 127;
			if (d > 255)
				d = 255;
			w[k / 4][POINT_W * (k % 4) +: POINT_W] = {d[DUTY_W-1:0], t[TEMP_W-1:0]};
		end
		for (int j = 0; j < 3; j++)
			write_reg(CFG_IDX_W'(int'(CFG_CPU_A) + 3 * ch + j), w[j]);
	endtask

	function automatic logic [3:0] pick_count();
		if ($urandom_range(99) < 15)
			return 4'($urandom_range(15));
		return 4'($urandom_range(2, 12));
	endfunction

	function automatic logic [6:0] pick_limit();
		if ($urandom_range(99) < 20)
			return 7'($urandom_range(127));
		return 7'($urandom_range(60, 127));
	endfunction

	task automatic program_phase(int phase);
		logic [WORD_W-1:0] word;
		case (phase)
			1: begin
				// empty curves, every valid reading critical
				for (int j = 0; j < 6; j++)
					write_reg(CFG_IDX_W'(int'(CFG_CPU_A) + j), '0);
				write_reg(CFG_COUNTS, '0);
				write_reg(CFG_CRIT, '0);
			end
			2: begin
				// all bits set: counts saturate, duties clamp, limits at top
				for (int j = 0; j < 6; j++)
					write_reg(CFG_IDX_W'(int'(CFG_CPU_A) + j), '1);
				write_reg(CFG_COUNTS, '1);
				write_reg(CFG_CRIT, '1);
			end
			3: begin
				program_curve(0, CURVE_SORTED);
				program_curve(1, CURVE_SORTED);
				write_reg(CFG_COUNTS, WORD_W'({4'd12, 4'd12}));
				write_reg(CFG_CRIT, WORD_W'({7'd95, 7'd110}));
			end
			default: begin
				program_curve(0, phase == 4 ? CURVE_SCRAMBLED : phase == 5 ? CURVE_STEPPED
					: curve_kind_t'($urandom_range(2)));
				program_curve(1, phase == 4 ? CURVE_SCRAMBLED : phase == 5 ? CURVE_STEPPED
					: curve_kind_t'($urandom_range(2)));
				word = WORD_W'({$urandom, $urandom});
				word[7:0] = {pick_count(), pick_count()};
				write_reg(CFG_COUNTS, word);
				word = WORD_W'({$urandom, $urandom});
				word[13:0] = {pick_limit(), pick_limit()};
				write_reg(CFG_CRIT, word);
			end
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic run_items(int count);
		temp_item_t it;
		repeat (count) begin
			cpu_walk = next_temp(cpu_walk);
			sys_walk = next_temp(sys_walk);
			it = mk_item(cpu_walk, $urandom_range(99) < 88, sys_walk, $urandom_range(99) < 88);
			if ($urandom_range(99) < 8)
				it = temp_item_t'(16'($urandom));
			send_item(it);
		end
		s_axis_tvalid <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default curves: no average yet, first load, deadband, limits
		send_item(mk_item(0, 0, 0, 0));
		send_item(mk_item(127, 0, 127, 0));
		send_item(mk_item(40, 1, 30, 1));
		send_item(mk_item(40, 1, 30, 1));
		send_item(mk_item(42, 1, 32, 1));
		send_item(mk_item(44, 1, 33, 1));
		send_item(mk_item(55, 1, 45, 1));
		send_item(mk_item(0, 1, 0, 1));
		send_item(mk_item(0, 1, 0, 1));
		send_item(mk_item(127, 0, 127, 0));
		send_item(mk_item(87, 1, 59, 1));
		send_item(mk_item(88, 1, 60, 1));
		send_item(mk_item(127, 1, 127, 1));
		send_item(mk_item(127, 1, 127, 1));
		send_item(mk_item(127, 0, 10, 1));
		send_item(mk_item(20, 1, 127, 0));
		send_item(mk_item(20, 1, 20, 1));
		send_item(mk_item(70, 1, 50, 1));
		send_item(mk_item(70, 1, 50, 1));
		send_item(mk_item(65, 1, 45, 1));
		send_item(mk_item(0, 0, 0, 0));
		send_item(mk_item(127, 1, 0, 1));
		s_axis_tvalid <= 1'b0;

		for (int phase = 1; phase <= PHASES; phase++) begin
			wait_results();
			program_phase(phase);
			steady <= (phase == 3);
			run_items(HALF_BATCH);
			wait_results();
			// mid-phase write: unused index keeps the held duties, a listed one drops them
			case ($urandom_range(2))
				0: write_reg(CFG_IDX_W'($urandom_range(int'(CFG_CRIT) + 1, int'(CFG_LAST_IDX))),
					WORD_W'({$urandom, $urandom}));
				1: write_reg(CFG_COUNTS, WORD_W'(sb.point_counts));
				default: ;
			endcase
			cfg_valid <= 1'b0;
			run_items(HALF_BATCH);
		end
		steady <= 1'b0;
		wait_results();
		repeat (64) @(posedge clk);

		$display("Sent %0d temperature ticks over %0d config phases with %0d register writes,",
			sb.items, PHASES + 1, sb.writes);
		$display("compared %0d duty results, %0d mismatched.", sb.results, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
